// File: hw/rtl/uqpt_pkg.sv
// Shared constants, codes and types for the URL query parameter tokenizer.
package uqpt_pkg;

	// Longest URI in bytes; the position counter can hold this value itself
	localparam int MAX_URI_BYTES = 1024;
	localparam int POS_W         = $clog2(MAX_URI_BYTES) + 1;
	localparam int PREFIX_LEN    = 10;
	localparam int PIDX_W        = $clog2(PREFIX_LEN);

	// Field widths of the request and result channels
	localparam int CHAR_W  = 8;
	localparam int KIND_W  = 2;
	localparam int IDX_W   = 4;
	localparam int FIELD_W = 10;
	localparam int MAXP_W  = 4;

	localparam logic [MAXP_W-1:0] MAXP_RESET = 4'd10;

	// Parse phases
	localparam int PHASE_W = 3;
	localparam logic [PHASE_W-1:0] PH_PREFIX      = 3'd0;
	localparam logic [PHASE_W-1:0] PH_NAME_START  = 3'd1;
	localparam logic [PHASE_W-1:0] PH_NAME        = 3'd2;
	localparam logic [PHASE_W-1:0] PH_VALUE_START = 3'd3;
	localparam logic [PHASE_W-1:0] PH_VALUE       = 3'd4;

	// Result kinds
	localparam logic [KIND_W-1:0] KIND_PAIR    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_END_OK  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_END_ERR = 2'd2;

	// Separator characters
	localparam logic [CHAR_W-1:0] CH_EQUALS = 8'h3d;
	localparam logic [CHAR_W-1:0] CH_AMP    = 8'h26;

	// Result queue
	localparam int RQ_DEPTH = 4;
	localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
	localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [IDX_W-1:0]   idx;
		logic [FIELD_W-1:0] name_off;
		logic [FIELD_W-1:0] name_len;
		logic [FIELD_W-1:0] arg_off;
		logic [FIELD_W-1:0] arg_len;
		logic               fin;
	} result_t;

	// Expected prefix "/ajax.cgi?", one byte per position
	function automatic logic [CHAR_W-1:0] prefix_byte(input logic [PIDX_W-1:0] idx);
		logic [CHAR_W-1:0] b;
		case (idx)
			4'd0:    b = 8'h2f;
			4'd1:    b = 8'h61;
			4'd2:    b = 8'h6a;
			4'd3:    b = 8'h61;
			4'd4:    b = 8'h78;
			4'd5:    b = 8'h2e;
			4'd6:    b = 8'h63;
			4'd7:    b = 8'h67;
			4'd8:    b = 8'h69;
			4'd9:    b = 8'h3f;
			default: b = '0;
		endcase
		return b;
	endfunction

endpackage

// File: hw/rtl/url_query_param_tokenizer.sv
// Top level of the URL query parameter tokenizer: byte parser and result queue.
//
// Usage: URI bytes arrive on the request channel (in_valid/in_ready, char_byte,
// last_byte), one byte per request, last_byte high on the final byte of a URI.
// The prefix "/ajax.cgi?" is checked, then each name=value pair is reported on
// the result channel (out_valid/out_ready) as a pair record; the final byte
// also yields an end record with success or error status, after which the
// parser is ready for the next URI. cfg_ready is always high; the user must write
// max_params over the cfg channel (cfg_valid/cfg_ready/cfg_data) only while the
// block is idle, which the block itself does not enforce.
// A request is held in the input register, parsed from there when the queue has
// room for two results, and its results are offered from the result queue.
// Throughput: one byte per cycle while the queue can take two results; a final
// byte closing a pending pair writes two results into the four-entry result queue.
// Stall: when out_ready is low the queue fills and in_ready drops once fewer
// than two queue entries are free; no request or result is lost.
// Reset: arst_n clears the parser state, empties the queue and sets max_params
// to ten; there is no clearing pass.
module url_query_param_tokenizer (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [uqpt_pkg::MAXP_W-1:0]    cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [uqpt_pkg::CHAR_W-1:0]    char_byte,
	input  logic                           last_byte,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [uqpt_pkg::KIND_W-1:0]    result_kind,
	output logic [uqpt_pkg::IDX_W-1:0]     pair_index,
	output logic [uqpt_pkg::FIELD_W-1:0]   name_offset,
	output logic [uqpt_pkg::FIELD_W-1:0]   name_length,
	output logic [uqpt_pkg::FIELD_W-1:0]   value_offset,
	output logic [uqpt_pkg::FIELD_W-1:0]   value_length,
	output logic                           final_result
);
	import uqpt_pkg::*;

	// Configuration register
	logic [MAXP_W-1:0] max_params_q;

	// Input register
	logic              valid_s1;
	logic [CHAR_W-1:0] char_s1;
	logic              last_s1;

	// Parser state
	logic [PHASE_W-1:0] phase_q, phase_n;
	logic [POS_W-1:0]   position_q, position_n;
	logic [POS_W-1:0]   run_q, run_n;
	logic [FIELD_W-1:0] pname_off_q, pname_off_n;
	logic [FIELD_W-1:0] pname_len_q, pname_len_n;
	logic [FIELD_W-1:0] pvalue_off_q, pvalue_off_n;
	logic [IDX_W-1:0]   pair_count_q, pair_count_n;
	logic               fault_q, fault_n;

	// Result queue
	result_t             rq_mem_q [RQ_DEPTH];
	logic [RQ_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [RQ_CNT_W-1:0] cnt_q;

	logic          adv;
	logic          pop;
	logic [1:0]    push;
	logic          pair_v;
	result_t       pair_rec, end_rec, rec_a, rec_b;
	logic [IDX_W-1:0] pc_inc;
	logic [RQ_PTR_W-1:0] wr_ptr_p1;

	assign cfg_ready = 1'b1;

	// Parse only when the queue can take two results
	assign adv      = valid_s1 && (cnt_q <= RQ_CNT_W'(RQ_DEPTH - 2));
	assign in_ready = !valid_s1 || adv;
	assign pop      = out_valid && out_ready;

	// Hold max_params
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_params_q <= MAXP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			max_params_q <= cfg_data;
		end
	end

	// Capture the request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1 <= char_byte;
			last_s1 <= last_byte;
		end
	end

	assign pc_inc = pair_count_q + IDX_W'(1);

	// Advance the parser by one byte
	always_comb begin
		phase_n      = phase_q;
		position_n   = position_q;
		run_n        = run_q;
		pname_off_n  = pname_off_q;
		pname_len_n  = pname_len_q;
		pvalue_off_n = pvalue_off_q;
		pair_count_n = pair_count_q;
		fault_n      = fault_q;
		pair_v       = 1'b0;
		pair_rec     = '0;
		end_rec      = '0;
		push         = 2'd0;

		if (adv && !fault_q) begin
			if (position_q >= POS_W'(MAX_URI_BYTES)) begin
				fault_n = 1'b1;
			end else begin
				unique case (phase_q)
					PH_PREFIX: begin
						if (position_q >= POS_W'(PREFIX_LEN) ||
						    char_s1 != prefix_byte(position_q[PIDX_W-1:0])) begin
							fault_n = 1'b1;
						end else if (position_q == POS_W'(PREFIX_LEN - 1)) begin
							phase_n = PH_NAME_START;
						end
					end
					PH_NAME_START: begin
						pname_off_n  = FIELD_W'(position_q);
						pname_len_n  = '0;
						pvalue_off_n = '0;
						phase_n      = PH_NAME;
					end
					PH_NAME: begin
						if (char_s1 == CH_EQUALS) begin
							pname_len_n = FIELD_W'(run_q);
							phase_n     = PH_VALUE_START;
						end
					end
					PH_VALUE_START: begin
						pvalue_off_n = FIELD_W'(position_q);
						phase_n      = PH_VALUE;
					end
					default: begin
						if (char_s1 == CH_AMP) begin
							pair_count_n = pc_inc;
							if (pc_inc == max_params_q) begin
								fault_n = 1'b1;
							end else begin
								pair_v = 1'b1;
							end
							phase_n = PH_NAME_START;
						end
					end
				endcase
				// A new name or value run starts at one after its first byte
				if (phase_q == PH_NAME_START || phase_q == PH_VALUE_START) begin
					run_n = POS_W'(1);
				end else begin
					run_n = run_q + POS_W'(1);
				end
				position_n = position_q + POS_W'(1);
			end
		end

		// Pair record closed by an ampersand
		if (pair_v) begin
			pair_rec.kind     = KIND_PAIR;
			pair_rec.idx      = pair_count_q;
			pair_rec.name_off = pname_off_q;
			pair_rec.name_len = pname_len_q;
			pair_rec.arg_off  = pvalue_off_q;
			pair_rec.arg_len  = FIELD_W'(run_q);
			pair_rec.fin      = 1'b0;
		end

		// Close the URI on its final byte
		if (adv && last_s1) begin
			if (!fault_n && phase_n == PH_PREFIX) begin
				fault_n = 1'b1;
			end
			if (!fault_n && phase_n == PH_VALUE) begin
				pair_v            = 1'b1;
				pair_rec.kind     = KIND_PAIR;
				pair_rec.idx      = pair_count_n;
				pair_rec.name_off = pname_off_n;
				pair_rec.name_len = pname_len_n;
				pair_rec.arg_off  = pvalue_off_n;
				pair_rec.arg_len  = FIELD_W'(run_n);
				pair_rec.fin      = 1'b0;
			end
			end_rec.kind = fault_n ? KIND_END_ERR : KIND_END_OK;
			end_rec.fin  = 1'b1;
			push         = pair_v ? 2'd2 : 2'd1;
			phase_n      = PH_PREFIX;
			position_n   = '0;
			run_n        = '0;
			pname_off_n  = '0;
			pname_len_n  = '0;
			pvalue_off_n = '0;
			pair_count_n = '0;
			fault_n      = 1'b0;
		end else if (pair_v) begin
			push = 2'd1;
		end

		rec_a = pair_v ? pair_rec : end_rec;
		rec_b = end_rec;
	end

	// Hold the parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_PREFIX;
			position_q   <= '0;
			run_q        <= '0;
			pname_off_q  <= '0;
			pname_len_q  <= '0;
			pvalue_off_q <= '0;
			pair_count_q <= '0;
			fault_q      <= 1'b0;
		end else begin
			phase_q      <= phase_n;
			position_q   <= position_n;
			run_q        <= run_n;
			pname_off_q  <= pname_off_n;
			pname_len_q  <= pname_len_n;
			pvalue_off_q <= pvalue_off_n;
			pair_count_q <= pair_count_n;
			fault_q      <= fault_n;
		end
	end

	assign wr_ptr_p1 = wr_ptr_q + RQ_PTR_W'(1);

	// Write up to two results into the queue
	always_ff @(posedge clk) begin
		if (push != 2'd0) begin
			rq_mem_q[wr_ptr_q] <= rec_a;
		end
		if (push == 2'd2) begin
			rq_mem_q[wr_ptr_p1] <= rec_b;
		end
	end

	// Advance queue pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + RQ_PTR_W'(push);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + RQ_PTR_W'(1);
			end
			cnt_q <= cnt_q + RQ_CNT_W'(push) - RQ_CNT_W'(pop);
		end
	end

	// Drive the result channel from the queue head
	assign out_valid    = (cnt_q != '0);
	assign result_kind  = rq_mem_q[rd_ptr_q].kind;
	assign pair_index   = rq_mem_q[rd_ptr_q].idx;
	assign name_offset  = rq_mem_q[rd_ptr_q].name_off;
	assign name_length  = rq_mem_q[rd_ptr_q].name_len;
	assign value_offset = rq_mem_q[rd_ptr_q].arg_off;
	assign value_length = rq_mem_q[rd_ptr_q].arg_len;
	assign final_result = rq_mem_q[rd_ptr_q].fin;

	// Queue never overflows
	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= RQ_CNT_W'(RQ_DEPTH))
		else $error("result queue overflow");

	// A final byte returns the parser to its starting state
	assert property (@(posedge clk) disable iff (!arst_n)
		adv && last_s1 |=> phase_q == PH_PREFIX && position_q == '0 && !fault_q)
		else $error("parser not cleared after final byte");

	// A faulted URI yields at most its end record per byte
	assert property (@(posedge clk) disable iff (!arst_n)
		adv && fault_q |-> push <= 2'd1 && !pair_v)
		else $error("pair record after fault");

	// Two results only on a final byte
	assert property (@(posedge clk) disable iff (!arst_n)
		push == 2'd2 |-> adv && last_s1)
		else $error("two results without final byte");

endmodule
